[hdl/bnr_pkg.sv]
`default_nettype none

package bnr_pkg;

  // fixed-point format and arithmetic sizes
  localparam int FRAC_BITS      = 16;
  localparam int SCALE_SHIFT    = 2 * FRAC_BITS - 16;
  localparam int MAG_W          = 33;
  localparam int PROD_W         = MAG_W + 16;
  localparam int SUM_W          = PROD_W + 1;
  localparam int IDX_W          = 24;
  localparam int TAG_W          = 24;
  localparam int BLK_REG_W      = 9;
  localparam int DEF_MAX_BLOCKS = 256;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_OVERLAP   = 3'd3;
  localparam logic [2:0] REG_INV_SIZE  = 3'd4;
  localparam logic [2:0] REG_BLOCKS_X  = 3'd5;
  localparam logic [2:0] REG_BLOCKS_Y  = 3'd6;
  localparam logic [2:0] REG_BLOCKS_Z  = 3'd7;

  localparam logic [31:0] INV_SIZE_RESET = 32'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [23:0]        point_id;
  } in_t;

  typedef struct packed {
    logic [23:0] block_index;
    logic [23:0] point_tag;
    logic        last_block;
  } out_t;

  typedef struct packed {
    logic signed [31:0]     origin_x;
    logic signed [31:0]     origin_y;
    logic signed [31:0]     origin_z;
    logic [30:0]            overlap_margin;
    logic [31:0]            inverse_block_size;
    logic [BLK_REG_W-1:0]   blocks_x;
    logic [BLK_REG_W-1:0]   blocks_y;
    logic [BLK_REG_W-1:0]   blocks_z;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       bnd_valid;
    logic [2:0] bnd_sel;
    logic       setup1;
    logic       setup2;
    logic       setup3;
    logic       emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[hdl/bnr_regs.sv]
`default_nettype none

module bnr_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bnr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bnr_pkg::DATA_W-1:0]  pwdata,
  output logic      [bnr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output bnr_pkg::cfg_t                    cfg
);

  bnr_pkg::cfg_t cfg_r;
  logic [2:0]    wr_idx;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_idx = paddr[bnr_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x           <= '0;
      cfg_r.origin_y           <= '0;
      cfg_r.origin_z           <= '0;
      cfg_r.overlap_margin     <= '0;
      cfg_r.inverse_block_size <= bnr_pkg::INV_SIZE_RESET;
      cfg_r.blocks_x           <= bnr_pkg::BLK_REG_W'(1);
      cfg_r.blocks_y           <= bnr_pkg::BLK_REG_W'(1);
      cfg_r.blocks_z           <= bnr_pkg::BLK_REG_W'(1);
    end else if (wr_en) begin
      unique case (wr_idx)
        bnr_pkg::REG_ORIGIN_X: cfg_r.origin_x <= pwdata;
        bnr_pkg::REG_ORIGIN_Y: cfg_r.origin_y <= pwdata;
        bnr_pkg::REG_ORIGIN_Z: cfg_r.origin_z <= pwdata;
        bnr_pkg::REG_OVERLAP:  cfg_r.overlap_margin <= pwdata[30:0];
        bnr_pkg::REG_INV_SIZE: cfg_r.inverse_block_size <= pwdata;
        bnr_pkg::REG_BLOCKS_X: cfg_r.blocks_x <= pwdata[bnr_pkg::BLK_REG_W-1:0];
        bnr_pkg::REG_BLOCKS_Y: cfg_r.blocks_y <= pwdata[bnr_pkg::BLK_REG_W-1:0];
        bnr_pkg::REG_BLOCKS_Z: cfg_r.blocks_z <= pwdata[bnr_pkg::BLK_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (wr_idx)
      bnr_pkg::REG_ORIGIN_X: prdata = cfg_r.origin_x;
      bnr_pkg::REG_ORIGIN_Y: prdata = cfg_r.origin_y;
      bnr_pkg::REG_ORIGIN_Z: prdata = cfg_r.origin_z;
      bnr_pkg::REG_OVERLAP:  prdata = {1'b0, cfg_r.overlap_margin};
      bnr_pkg::REG_INV_SIZE: prdata = cfg_r.inverse_block_size;
      bnr_pkg::REG_BLOCKS_X: prdata = bnr_pkg::DATA_W'(cfg_r.blocks_x);
      bnr_pkg::REG_BLOCKS_Y: prdata = bnr_pkg::DATA_W'(cfg_r.blocks_y);
      bnr_pkg::REG_BLOCKS_Z: prdata = bnr_pkg::DATA_W'(cfg_r.blocks_z);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/bnr_dp.sv]
`default_nettype none

module bnr_dp #(
  parameter int MAX_BLOCKS_PER_AXIS = bnr_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire bnr_pkg::cfg_t   cfg,
  input  wire bnr_pkg::cmd_t   cmd,
  input  wire bnr_pkg::in_t    in_data,
  output bnr_pkg::status_t     status,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bnr_pkg::out_t        out_data
);

  localparam int AXIS_W = (MAX_BLOCKS_PER_AXIS > 1) ? $clog2(MAX_BLOCKS_PER_AXIS) : 1;
  localparam int DIM_W  = AXIS_W + 1;
  localparam int IDX_W  = bnr_pkg::IDX_W;
  localparam int PROD_W = bnr_pkg::PROD_W;
  localparam int SUM_W  = bnr_pkg::SUM_W;
  localparam int MAG_W  = bnr_pkg::MAG_W;
  localparam int BLK_REG_W_L = bnr_pkg::BLK_REG_W;
  localparam logic [DIM_W-1:0] SAT = DIM_W'(MAX_BLOCKS_PER_AXIS);

  // captured point
  bnr_pkg::in_t pt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_r <= in_data;
    end
  end

  // bound unit stage 0: offset from origin plus or minus the margin
  logic [1:0]   s0_axis;
  logic         s0_hi;
  logic [31:0]  s0_pt;
  logic [31:0]  s0_org;
  logic [33:0]  s0_rel;
  logic [33:0]  s0_v;

  assign s0_axis = cmd.bnd_sel[2:1];
  assign s0_hi   = cmd.bnd_sel[0];

  always_comb begin
    unique case (s0_axis)
      2'd0: begin
        s0_pt  = pt_r.point_x;
        s0_org = cfg.origin_x;
      end
      2'd1: begin
        s0_pt  = pt_r.point_y;
        s0_org = cfg.origin_y;
      end
      default: begin
        s0_pt  = pt_r.point_z;
        s0_org = cfg.origin_z;
      end
    endcase
    s0_rel = {{2{s0_pt[31]}}, s0_pt} - {{2{s0_org[31]}}, s0_org};
    s0_v   = s0_hi ? s0_rel + {3'b000, cfg.overlap_margin}
                   : s0_rel - {3'b000, cfg.overlap_margin};
  end

  logic             s0_valid_r;
  logic [2:0]       s0_sel_r;
  logic             s0_neg_r;
  logic [MAG_W-1:0] s0_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= cmd.bnd_valid;
    end
  end

  // a zero inverse size scales any offset, negative too, to block 0
  always_ff @(posedge clk) begin
    s0_sel_r <= cmd.bnd_sel;
    s0_neg_r <= s0_v[33] & (|cfg.inverse_block_size);
    s0_mag_r <= s0_v[33] ? '0 : s0_v[MAG_W-1:0];
  end

  // stage 1: split multiply by the inverse block size
  logic              s1_valid_r;
  logic [2:0]        s1_sel_r;
  logic              s1_neg_r;
  logic [PROD_W-1:0] prod_hi_r;
  logic [PROD_W-1:0] prod_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_sel_r  <= s0_sel_r;
    s1_neg_r  <= s0_neg_r;
    prod_hi_r <= PROD_W'(s0_mag_r) * PROD_W'(cfg.inverse_block_size[31:16]);
    prod_lo_r <= PROD_W'(s0_mag_r) * PROD_W'(cfg.inverse_block_size[15:0]);
  end

  // stage 2: floor of the scaled product, saturated at MAX_BLOCKS_PER_AXIS
  logic [SUM_W-1:0] s2_sum;
  logic [SUM_W-1:0] s2_q;
  logic [DIM_W-1:0] s2_bnd;

  always_comb begin
    s2_sum = SUM_W'(prod_hi_r) + SUM_W'(prod_lo_r >> 16);
    s2_q   = s2_sum >> bnr_pkg::SCALE_SHIFT;
    s2_bnd = (s2_q >= SUM_W'(MAX_BLOCKS_PER_AXIS)) ? SAT : s2_q[DIM_W-1:0];
  end

  logic [DIM_W-1:0] lo_r   [3];
  logic [DIM_W-1:0] hi_r   [3];
  logic             hneg_r [3];

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      if (s1_sel_r[0]) begin
        hi_r[s1_sel_r[2:1]]   <= s2_bnd;
        hneg_r[s1_sel_r[2:1]] <= s1_neg_r;
      end else begin
        lo_r[s1_sel_r[2:1]] <= s1_neg_r ? '0 : s2_bnd;
      end
    end
  end

  // setup 1: clamp, empty check, span and grid strides
  logic [BLK_REG_W_L-1:0] blk_reg [3];
  logic [DIM_W-1:0]   dim   [3];
  logic [DIM_W-1:0]   h_cl  [3];
  logic [DIM_W-1:0]   diff  [3];
  logic [1:0]         span  [3];
  logic [2:0]         ax_empty;
  logic [2*DIM_W-1:0] nynz_full;

  assign blk_reg[0] = cfg.blocks_x;
  assign blk_reg[1] = cfg.blocks_y;
  assign blk_reg[2] = cfg.blocks_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (blk_reg[a] == '0) begin
        dim[a] = DIM_W'(1);
      end else if (32'(blk_reg[a]) > 32'(MAX_BLOCKS_PER_AXIS)) begin
        dim[a] = SAT;
      end else begin
        dim[a] = DIM_W'(blk_reg[a]);
      end
      h_cl[a]     = (hi_r[a] > dim[a] - DIM_W'(1)) ? dim[a] - DIM_W'(1) : hi_r[a];
      ax_empty[a] = hneg_r[a] | (h_cl[a] < lo_r[a]);
      diff[a]     = h_cl[a] - lo_r[a];
      span[a]     = (diff[a] > DIM_W'(2)) ? 2'd2 : diff[a][1:0];
    end
    nynz_full = dim[1] * dim[2];
  end

  logic [AXIS_W-1:0] low_r  [3];
  logic [1:0]        span_r [3];
  logic              empty_r;
  logic [DIM_W-1:0]  nz_r;
  logic [IDX_W-1:0]  nynz_r;

  always_ff @(posedge clk) begin
    if (cmd.setup1) begin
      for (int a = 0; a < 3; a++) begin
        low_r[a]  <= lo_r[a][AXIS_W-1:0];
        span_r[a] <= span[a];
      end
      empty_r <= |ax_empty;
      nz_r    <= dim[2];
      nynz_r  <= IDX_W'(nynz_full);
    end
  end

  // setup 2: plane and row offsets of the first block
  logic [AXIS_W+IDX_W-1:0] xb_full;
  logic [AXIS_W+DIM_W-1:0] yb_full;
  logic [IDX_W-1:0]        xb_r;
  logic [IDX_W-1:0]        yb_r;

  assign xb_full = low_r[0] * nynz_r;
  assign yb_full = low_r[1] * nz_r;

  always_ff @(posedge clk) begin
    if (cmd.setup2) begin
      xb_r <= IDX_W'(xb_full);
      yb_r <= IDX_W'(yb_full);
    end
  end

  // setup 3 and emit: walk the block ranges, z innermost
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] xbase_r;
  logic [IDX_W-1:0] ybase_r;
  logic [1:0]       cx_r;
  logic [1:0]       cy_r;
  logic [1:0]       cz_r;
  logic [IDX_W-1:0] base;
  logic             is_last;

  assign base    = xb_r + yb_r + IDX_W'(low_r[2]);
  assign is_last = (cx_r == span_r[0]) && (cy_r == span_r[1]) && (cz_r == span_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.setup3) begin
      idx_r   <= base;
      xbase_r <= base;
      ybase_r <= base;
      cx_r    <= '0;
      cy_r    <= '0;
      cz_r    <= '0;
    end else if (cmd.emit) begin
      if (cz_r != span_r[2]) begin
        idx_r <= idx_r + IDX_W'(1);
        cz_r  <= cz_r + 2'd1;
      end else if (cy_r != span_r[1]) begin
        idx_r   <= ybase_r + IDX_W'(nz_r);
        ybase_r <= ybase_r + IDX_W'(nz_r);
        cy_r    <= cy_r + 2'd1;
        cz_r    <= '0;
      end else if (cx_r != span_r[0]) begin
        idx_r   <= xbase_r + nynz_r;
        xbase_r <= xbase_r + nynz_r;
        ybase_r <= xbase_r + nynz_r;
        cx_r    <= cx_r + 2'd1;
        cy_r    <= '0;
        cz_r    <= '0;
      end
    end
  end

  // output register
  logic          out_valid_r;
  bnr_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.block_index <= idx_r;
      out_data_r.point_tag   <= pt_r.point_id;
      out_data_r.last_block  <= is_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.empty    = empty_r;
  assign status.last     = is_last;
  assign status.out_free = ~out_valid_r | out_ready;

endmodule

`default_nettype wire

[hdl/bnr_ctrl.sv]
`default_nettype none

module bnr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bnr_pkg::status_t status,
  output bnr_pkg::cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_BOUND  = 3'd1;
  localparam logic [2:0] ST_SETUP1 = 3'd2;
  localparam logic [2:0] ST_SETUP2 = 3'd3;
  localparam logic [2:0] ST_SETUP3 = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  // six bounds issued, then wait for the bound unit to drain
  localparam int         NUM_BOUNDS = 6;
  localparam int         BND_DEPTH  = 2;
  localparam logic [2:0] BND_ISSUE  = 3'(NUM_BOUNDS - 1);
  localparam logic [2:0] BND_DONE   = 3'(NUM_BOUNDS + BND_DEPTH - 1);

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] cnt_r;
  logic [2:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.bnd_sel   = cnt_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        cmd.bnd_valid = (cnt_r <= BND_ISSUE);
        cnt_nxt       = cnt_r + 3'd1;
        if (cnt_r == BND_DONE) begin
          state_nxt = ST_SETUP1;
        end
      end
      ST_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = ST_SETUP2;
      end
      ST_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = status.empty ? ST_IDLE : ST_SETUP3;
      end
      ST_SETUP3: begin
        cmd.setup3 = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/point_to_overlapping_block_binner.sv]
`default_nettype none

// Bins one signed Q16.16 point into a uniform grid of overlapping blocks and
// returns the flat index x*ny*nz + y*nz + z of every block whose margin-grown
// extent holds the point, x outermost, z innermost, with last_block on the
// final one; a point outside the grid returns nothing. Each axis range is at
// most three blocks, so one point yields 1 to 27 results. The six floor
// bounds pass one at a time through the shared three-stage scale unit (two
// 33x16 multipliers), three setup steps then build the starting index, and
// one block leaves per cycle while the output is not stalled. A point that
// returns nothing frees the input once the setup finds its range empty.
// The next point is taken once the last block sits in the output register.
// Registers live on the APB port at byte address 4*i: origin_x, origin_y,
// origin_z, overlap_margin, inverse_block_size, blocks_x, blocks_y, blocks_z;
// write them only while the block is idle.
module point_to_overlapping_block_binner #(
  parameter int MAX_BLOCKS_PER_AXIS = bnr_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire bnr_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bnr_pkg::out_t                    out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bnr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bnr_pkg::DATA_W-1:0]  pwdata,
  output logic      [bnr_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  bnr_pkg::cfg_t    cfg;
  bnr_pkg::cmd_t    cmd;
  bnr_pkg::status_t status;

  // configuration registers
  bnr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  bnr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // bounds, index walk and output register
  bnr_dp #(
    .MAX_BLOCKS_PER_AXIS (MAX_BLOCKS_PER_AXIS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // an accepted point keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("input reopened right after a transaction");

  // a point's blocks are never interleaved with the next point
  a_no_accept_mid_point: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_block |-> !in_ready
  ) else $error("input open while a point still has blocks to send");

endmodule

`default_nettype wire

[verif/bnr_checker.sv]
module bnr_checker
  import bnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t grid;
  out_t blocks_due[$];
  out_t want;
  int   err_count = 0;

  // zero acts as one block, oversize saturates
  function automatic int eff_blocks(logic [BLK_REG_W-1:0] r);
    if (r == 0) return 1;
    if (r > DEF_MAX_BLOCKS) return DEF_MAX_BLOCKS;
    return int'(r);
  endfunction

  // clamped block range on one axis, 0 when the range is empty
  function automatic bit axis_bounds(logic signed [31:0] pt, logic signed [31:0] org, int dim,
                                     output int lo, output int hi);
    longint rel, mrg, l, h;
    logic signed [99:0] lo_prod, hi_prod;
    rel = longint'(pt) - longint'(org);
    mrg = longint'(grid.overlap_margin);
    // exact product, floor taken by the arithmetic shift
    lo_prod = (rel - mrg) * $signed({1'b0, grid.inverse_block_size});
    hi_prod = (rel + mrg) * $signed({1'b0, grid.inverse_block_size});
    l = longint'(lo_prod >>> (2 * FRAC_BITS));
    h = longint'(hi_prod >>> (2 * FRAC_BITS));
    if (l < 0) l = 0;
    if (h > dim - 1) h = dim - 1;
    if (h < l) return 1'b0;
    // wide margin: at most three blocks per axis
    if (h > l + 2) h = l + 2;
    lo = int'(l);
    hi = int'(h);
    return 1'b1;
  endfunction

  // queue every block the point overlaps, x outermost, z innermost
  function automatic void bin_point(in_t p);
    int nx, ny, nz, xl, xh, yl, yh, zl, zh;
    out_t blk;
    nx = eff_blocks(grid.blocks_x);
    ny = eff_blocks(grid.blocks_y);
    nz = eff_blocks(grid.blocks_z);
    if (!axis_bounds(p.point_x, grid.origin_x, nx, xl, xh)) return;
    if (!axis_bounds(p.point_y, grid.origin_y, ny, yl, yh)) return;
    if (!axis_bounds(p.point_z, grid.origin_z, nz, zl, zh)) return;
    for (int bx = xl; bx <= xh; bx++) begin
      for (int by = yl; by <= yh; by++) begin
        for (int bz = zl; bz <= zh; bz++) begin
          blk.block_index = IDX_W'(bx * ny * nz + by * nz + bz);
          blk.point_tag   = p.point_id;
          blk.last_block  = (bx == xh && by == yh && bz == zh);
          blocks_due = {blocks_due, blk};
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      grid.origin_x           = '0;
      grid.origin_y           = '0;
      grid.origin_z           = '0;
      grid.overlap_margin     = '0;
      grid.inverse_block_size = INV_SIZE_RESET;
      grid.blocks_x           = BLK_REG_W'(1);
      grid.blocks_y           = BLK_REG_W'(1);
      grid.blocks_z           = BLK_REG_W'(1);
      blocks_due.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ORIGIN_X: grid.origin_x = pwdata;
          REG_ORIGIN_Y: grid.origin_y = pwdata;
          REG_ORIGIN_Z: grid.origin_z = pwdata;
          REG_OVERLAP:  grid.overlap_margin = pwdata[30:0];
          REG_INV_SIZE: grid.inverse_block_size = pwdata;
          REG_BLOCKS_X: grid.blocks_x = pwdata[BLK_REG_W-1:0];
          REG_BLOCKS_Y: grid.blocks_y = pwdata[BLK_REG_W-1:0];
          REG_BLOCKS_Z: grid.blocks_z = pwdata[BLK_REG_W-1:0];
          default: ;
        endcase
      end
      // point transaction
      if (in_valid && in_ready) bin_point(in_data);
      // block transaction against the oldest expected block
      if (out_valid && out_ready) begin
        if (blocks_due.size() == 0) begin
          $display("%0t: unexpected block, got index %0d tag %0h last %0b", $time,
                   out_data.block_index, out_data.point_tag, out_data.last_block);
          err_count++;
        end else begin
          want = blocks_due.pop_front();
          if (out_data !== want) begin
            if (out_data.block_index !== want.block_index)
              $display("%0t: block_index expected %0d got %0d", $time,
                       want.block_index, out_data.block_index);
            if (out_data.point_tag !== want.point_tag)
              $display("%0t: point_tag expected %0h got %0h", $time,
                       want.point_tag, out_data.point_tag);
            if (out_data.last_block !== want.last_block)
              $display("%0t: last_block expected %0b got %0b", $time,
                       want.last_block, out_data.last_block);
            err_count++;
          end
        end
      end
    end
    outstanding <= blocks_due.size();
    mismatches  <= err_count;
  end

endmodule

[verif/tb_top.sv]
module tb_top
  import bnr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef enum {RX_OPEN, RX_COIN, RX_PULSE, RX_MOSTLY} rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                mismatches;
  int                outstanding;
  int                cycle_count = 0;
  int                burst_left = 0;
  rx_mode_t          rx_mode = RX_OPEN;
  int                rx_tick = 0;

  // grid as last programmed, used only to aim the points
  logic signed [31:0] g_org [3];
  longint             g_margin;
  longint             g_inv;
  int                 g_dim [3];

  always #4 clk = ~clk;

  point_to_overlapping_block_binner u_top (.*);

  bnr_checker u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver stalls in a pattern picked at random from four modes
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 96 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= ($urandom_range(0, 1) == 1);
      RX_PULSE: out_ready <= (rx_tick % 7) < 2;
      default:  out_ready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic reg_write(logic [2:0] idx, logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stop sending and wait out every pending block
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_grid(logic [31:0] ox, oy, oz, margin, inv, logic [8:0] bx, by, bz);
    settle();
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_OVERLAP, margin);
    reg_write(REG_INV_SIZE, inv);
    reg_write(REG_BLOCKS_X, 32'(bx));
    reg_write(REG_BLOCKS_Y, 32'(by));
    reg_write(REG_BLOCKS_Z, 32'(bz));
    g_org[0] = ox;
    g_org[1] = oy;
    g_org[2] = oz;
    g_margin = longint'(margin[30:0]);
    g_inv    = longint'(inv);
    g_dim[0] = (bx == 0) ? 1 : ((bx > 256) ? 256 : int'(bx));
    g_dim[1] = (by == 0) ? 1 : ((by > 256) ? 256 : int'(by));
    g_dim[2] = (bz == 0) ? 1 : ((bz > 256) ? 256 : int'(bz));
  endtask

  // one point transaction, bursts with random gaps in between
  task automatic send_point(in_t p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // coordinate near the grid: inside a block, on an edge, on a margin edge, or noise
  function automatic logic [31:0] grid_coord(int axis);
    longint bsize, base, off;
    int blk, nudge, pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return $urandom();
    bsize = (g_inv == 0) ? 64'h1_0000 : 64'h1_0000_0000 / g_inv;
    blk   = int'($urandom_range(0, g_dim[axis] + 1)) - 1;
    base  = longint'(blk) * bsize;
    nudge = int'($urandom_range(0, 4)) - 2;
    case (pick % 4)
      0:       off = base + longint'($urandom) % bsize;
      1:       off = base + nudge;
      2:       off = base + g_margin + nudge;
      default: off = base - g_margin + nudge;
    endcase
    return 32'(longint'(g_org[axis]) + off);
  endfunction

  task automatic run_random(int count, bit hold_mid);
    for (int k = 0; k < count; k++) begin
      if (hold_mid && k == count / 2) settle();
      send_point(in_t'{grid_coord(0), grid_coord(1), grid_coord(2), 24'($urandom)});
    end
  endtask

  initial begin
    g_org    = '{32'sd0, 32'sd0, 32'sd0};
    g_margin = 0;
    g_inv    = 64'h1_0000;
    g_dim    = '{1, 1, 1};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset grid: one unit block at the origin
    send_point(in_t'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0000});
    send_point(in_t'{32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 24'hFF_FFFF});
    send_point(in_t'{32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 24'h00_0001});
    send_point(in_t'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 24'h00_0002});
    send_point(in_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_0003});
    send_point(in_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0004});

    // lowest origin, half-block margin, 4x4x4 unit blocks
    set_grid(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_8000, 32'h0001_0000,
             9'd4, 9'd4, 9'd4);
    send_point(in_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0005});
    send_point(in_t'{32'h8001_8000, 32'h8001_8000, 32'h8001_8000, 24'hA5_A5A5});
    send_point(in_t'{32'h8003_FFFF, 32'h8003_FFFF, 32'h8003_FFFF, 24'h5A_5A5A});
    send_point(in_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_0009});
    run_random(35, 1'b0);

    // margin far above block size, zero and oversize block counts
    set_grid(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0001_0000, 9'd511, 9'd256, 9'd0);
    send_point(in_t'{32'h0002_0000, 32'h7FFF_FFFF, 32'h0000_0000, 24'h00_0006});
    send_point(in_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0007});
    run_random(25, 1'b0);

    // zero inverse size: everything lands in block 0
    set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 9'd3, 9'd3, 9'd3);
    send_point(in_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 24'h00_0008});
    send_point(in_t'{32'h7FFF_FFFF, 32'h0000_0000, 32'h1234_5678, 24'h12_3456});
    run_random(12, 1'b0);

    // largest inverse size: blocks one lsb wide, up to 27 blocks per point
    set_grid(32'h7FFF_F000, 32'h7FFF_F000, 32'h7FFF_F000, 32'h1, 32'hFFFF_FFFF,
             9'd256, 9'd256, 9'd256);
    send_point(in_t'{32'h7FFF_F000, 32'h7FFF_F000, 32'h7FFF_F000, 24'h00_000A});
    send_point(in_t'{32'h7FFF_F080, 32'h7FFF_F080, 32'h7FFF_F080, 24'h00_000B});
    send_point(in_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_000C});
    run_random(40, 1'b0);

    // smallest nonzero inverse size: one huge block
    set_grid(32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 9'd2, 9'd2, 9'd2);
    send_point(in_t'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h00_000D});
    run_random(15, 1'b0);

    // typical grid: 4.0 blocks, 1.0 overlap, sender holds off halfway
    set_grid(32'hFFF0_0000, 32'hFFF0_0000, 32'hFFF0_0000, 32'h0001_0000, 32'h0000_4000,
             9'd5, 9'd7, 9'd3);
    run_random(60, 1'b1);

    // margin equal to the block size
    set_grid(32'h0010_0000, 32'hFFFF_0000, 32'h0, 32'h0008_0000, 32'h0000_2000,
             9'd256, 9'd1, 9'd2);
    run_random(40, 1'b0);

    // random grids
    for (int r = 0; r < 2; r++) begin
      set_grid($urandom, $urandom, $urandom, $urandom_range(0, 32'h4_0000),
               $urandom_range(32'h800, 32'h8_0000), 9'($urandom_range(0, 300)),
               9'($urandom_range(0, 300)), 9'($urandom_range(0, 300)));
      run_random(25, 1'b0);
    end

    settle();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
